@@ sv/lcpac_pkg.sv @@
// Shared widths, register codes and the result structure of the LCP alpha-cluster detector.
`timescale 1ns / 1ps
`default_nettype none

package lcpac_pkg;

    localparam int POS_W = 40;
    localparam int LCP_W = 8;

    // Stream data widths, rounded up to whole bytes.
    localparam int IN_TDATA_W   = ((LCP_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 4 * POS_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register index, taken from paddr[2].
    typedef enum logic {
        REG_ALPHA    = 1'b0,
        REG_POS_MODE = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic             emit;
        logic             has_cluster;
        logic [POS_W-1:0] cluster_start;
        logic [POS_W-1:0] cluster_length;
        logic [POS_W-1:0] longest_length;
        logic [POS_W-1:0] cluster_count;
        logic             end_of_stream;
    } result_t;

endpackage

`default_nettype wire

@@ sv/lcpac_core.sv @@
// Per-item cluster tracking state and its combinational update logic.
`timescale 1ns / 1ps
`default_nettype none

module lcpac_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       step,
    input  wire logic                       func,
    input  wire logic [lcpac_pkg::LCP_W-1:0] lcp_value,
    input  wire logic [7:0]                 alpha,
    input  wire logic                       positional_mode,
    output lcpac_pkg::result_t              res
);

    logic [lcpac_pkg::POS_W-1:0] position_reg, position_next;
    logic                        skipping_reg, skipping_next;
    logic                        open_reg, open_next;
    logic [lcpac_pkg::POS_W-1:0] open_start_reg, open_start_next;
    logic [lcpac_pkg::LCP_W-1:0] prev_reg, prev_next;
    logic                        growing_reg, growing_next;
    logic [lcpac_pkg::POS_W-1:0] plateau_reg, plateau_next;
    logic [lcpac_pkg::POS_W-1:0] longest_reg, longest_next;
    logic [lcpac_pkg::POS_W-1:0] count_reg, count_next;

    logic [lcpac_pkg::LCP_W-1:0] alpha_ext;
    logic                        at_alpha;
    logic                        close_en;
    logic [lcpac_pkg::POS_W-1:0] close_end;
    logic [lcpac_pkg::POS_W-1:0] close_len;
    logic [lcpac_pkg::POS_W-1:0] pos_m1;

    assign alpha_ext = lcpac_pkg::LCP_W'(alpha);
    assign at_alpha  = (lcp_value >= alpha_ext);
    assign pos_m1    = position_reg - lcpac_pkg::POS_W'(1);

    always_comb
    begin
        position_next   = position_reg;
        skipping_next   = skipping_reg;
        open_next       = open_reg;
        open_start_next = open_start_reg;
        prev_next       = prev_reg;
        growing_next    = growing_reg;
        plateau_next    = plateau_reg;
        longest_next    = longest_reg;
        count_next      = count_reg;
        close_en        = 1'b0;
        close_end       = position_reg;

        res                = '0;
        res.longest_length = longest_reg;
        res.cluster_count  = count_reg;

        if (func)
        begin
            res.emit          = 1'b1;
            res.end_of_stream = 1'b1;
            close_en          = open_reg;
        end
        else
        begin
            if (skipping_reg)
            begin
                if (!at_alpha)
                begin
                    skipping_next = 1'b0;
                end
            end
            else if (at_alpha)
            begin
                if (!open_reg)
                begin
                    open_next       = 1'b1;
                    open_start_next = pos_m1;
                    growing_next    = 1'b1;
                    plateau_next    = '0;
                end
                else if (positional_mode)
                begin
                    if (lcp_value < prev_reg)
                    begin
                        // Falling: either the first descent or a new, lower floor.
                        growing_next = 1'b0;
                        if (!growing_reg)
                        begin
                            plateau_next = '0;
                        end
                    end
                    else if (!growing_reg && lcp_value == prev_reg)
                    begin
                        if (!(&plateau_reg))
                        begin
                            plateau_next = plateau_reg + lcpac_pkg::POS_W'(1);
                        end
                    end
                    else if (!growing_reg && lcp_value > prev_reg)
                    begin
                        // Rise after a valley: close before the floor plateau, reopen on it.
                        close_en        = 1'b1;
                        close_end       = pos_m1 - plateau_reg;
                        res.emit        = 1'b1;
                        open_start_next = position_reg - plateau_reg;
                        growing_next    = 1'b1;
                        plateau_next    = '0;
                    end
                end
                if (positional_mode)
                begin
                    prev_next = lcp_value;
                end
            end
            else
            begin
                if (open_reg)
                begin
                    close_en = 1'b1;
                    res.emit = 1'b1;
                end
                open_next = 1'b0;
            end

            if (!(&position_reg))
            begin
                position_next = position_reg + lcpac_pkg::POS_W'(1);
            end
        end

        close_len = close_end - open_start_reg;

        if (close_en)
        begin
            if (close_len > longest_reg)
            begin
                longest_next = close_len;
            end
            if (!(&count_reg))
            begin
                count_next = count_reg + lcpac_pkg::POS_W'(1);
            end
            res.has_cluster    = 1'b1;
            res.cluster_start  = open_start_reg;
            res.cluster_length = close_len;
            res.longest_length = longest_next;
            res.cluster_count  = count_next;
        end

        // A flush starts a new stream once its result is formed.
        if (func)
        begin
            position_next   = '0;
            skipping_next   = 1'b1;
            open_next       = 1'b0;
            open_start_next = '0;
            prev_next       = '1;
            growing_next    = 1'b1;
            plateau_next    = '0;
            longest_next    = '0;
            count_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg   <= '0;
            skipping_reg   <= 1'b1;
            open_reg       <= 1'b0;
            open_start_reg <= '0;
            prev_reg       <= '1;
            growing_reg    <= 1'b1;
            plateau_reg    <= '0;
            longest_reg    <= '0;
            count_reg      <= '0;
        end
        else if (step)
        begin
            position_reg   <= position_next;
            skipping_reg   <= skipping_next;
            open_reg       <= open_next;
            open_start_reg <= open_start_next;
            prev_reg       <= prev_next;
            growing_reg    <= growing_next;
            plateau_reg    <= plateau_next;
            longest_reg    <= longest_next;
            count_reg      <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/lcp_alpha_cluster_detector.sv @@
// Top level of the LCP alpha-cluster detector: stream stages and register port.
//
//   Channel  Direction  Carries
//   s_*      in         one LCP sample or a flush (tuser) per transaction
//   m_*      out        closed cluster and running totals, tlast on flush answer
//   APB      in/out     alpha and positional_mode registers
//
// One item per cycle is sustained while the output is not stalled; an item is held
// in the input register and its result, if any, in the result register. The state
// update in lcpac_core is combinational, which sets that rate. Reset puts the stream
// state back into leading skip with no open cluster and clears the alpha and
// positional_mode registers to zero. While a result waits with m_tready low the
// result register holds and the input register fills, then s_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module lcp_alpha_cluster_detector (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [lcpac_pkg::IN_TDATA_W-1:0] s_tdata,  // lcp_value
    input  wire logic                             s_tuser,  // func (1 = flush)
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // cluster_start, cluster_length, longest_length, cluster_count
    output logic [lcpac_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                  m_tuser,  // has_cluster
    output logic                                  m_tlast,  // end_of_stream
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [lcpac_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [lcpac_pkg::APB_DATA_W-1:0] pwdata,
    output logic [lcpac_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                  pready
);

    logic                        in_valid_reg, in_valid_next;
    logic                        in_func_reg;
    logic [lcpac_pkg::LCP_W-1:0] in_lcp_reg;
    logic                        out_valid_reg, out_valid_next;
    lcpac_pkg::result_t          out_res_reg;
    logic [7:0]                  alpha_reg, alpha_next;
    logic                        pmode_reg, pmode_next;

    lcpac_pkg::result_t          res;
    lcpac_pkg::reg_idx_t         reg_idx;
    logic                        out_free;
    logic                        step;
    logic                        in_take;
    logic                        cfg_write;

    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || step;
    assign in_take  = s_tvalid && s_tready;

    lcpac_core u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (step),
        .func            (in_func_reg),
        .lcp_value       (in_lcp_reg),
        .alpha           (alpha_reg),
        .positional_mode (pmode_reg),
        .res             (res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (step && res.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Register port: pready is always high, so an access never waits.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = lcpac_pkg::reg_idx_t'(paddr[2]);

    always_comb
    begin
        alpha_next = alpha_reg;
        pmode_next = pmode_reg;
        prdata     = '0;
        unique case (reg_idx)
            lcpac_pkg::REG_ALPHA:
            begin
                prdata = lcpac_pkg::APB_DATA_W'(alpha_reg);
                if (cfg_write)
                begin
                    alpha_next = pwdata[7:0];
                end
            end
            lcpac_pkg::REG_POS_MODE:
            begin
                prdata = lcpac_pkg::APB_DATA_W'(pmode_reg);
                if (cfg_write)
                begin
                    pmode_next = pwdata[0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            alpha_reg     <= '0;
            pmode_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            alpha_reg     <= alpha_next;
            pmode_reg     <= pmode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_func_reg <= s_tuser;
            in_lcp_reg  <= s_tdata[lcpac_pkg::LCP_W-1:0];
        end
        if (step && res.emit)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.has_cluster;
    assign m_tlast  = out_res_reg.end_of_stream;
    assign m_tdata  = lcpac_pkg::OUT_TDATA_W'({out_res_reg.cluster_count,
                                               out_res_reg.longest_length,
                                               out_res_reg.cluster_length,
                                               out_res_reg.cluster_start});

endmodule

`default_nettype wire

@@ sv/lcpac_checker.sv @@
// Port-level checks on the result stream of the LCP alpha-cluster detector.
`timescale 1ns / 1ps
`default_nettype none

module lcpac_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [lcpac_pkg::OUT_TDATA_W-1:0] m_tdata,
    input wire logic                             m_tuser,
    input wire logic                             m_tlast
);

    localparam int W = lcpac_pkg::POS_W;

    logic [W-1:0] start_f;
    logic [W-1:0] length_f;
    logic [W-1:0] longest_f;

    assign start_f   = m_tdata[W-1:0];
    assign length_f  = m_tdata[2*W-1:W];
    assign longest_f = m_tdata[3*W-1:2*W];

    // A stalled result keeps its contents.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

    // A sample transaction only produces a result when it closes a cluster.
    a_no_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser || m_tlast)
        else $error("result carries neither a cluster nor end of stream");

    // A flush with no open cluster reports a zero start and length.
    a_empty_flush: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> start_f == '0 && length_f == '0)
        else $error("empty flush result has nonzero start or length");

    // The running maximum already includes the cluster being reported.
    a_longest: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> length_f <= longest_f)
        else $error("cluster longer than running maximum");

endmodule

bind lcp_alpha_cluster_detector lcpac_checker u_lcpac_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for the LCP alpha-cluster detector stream and register port.
`timescale 1ns / 1ps

module tb;
    import lcpac_pkg::*;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_FLUSH  = 1'b1;
    localparam int   LCP_MAX     = (1 << LCP_W) - 1;
    localparam logic [POS_W-1:0] POS_MAX = '1;
    localparam int   HOLD_CYCLES = 64;
    localparam int   DRAIN_CYCLES = 4;
    localparam int   CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic             has_cluster;
        logic [POS_W-1:0] start;
        logic [POS_W-1:0] length;
        logic [POS_W-1:0] longest;
        logic [POS_W-1:0] count;
        logic             end_of_stream;
    } cluster_report_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    // Predictor copy of the registers and the stream state.
    logic [LCP_W-1:0] cfg_alpha;
    logic             cfg_positional;
    logic [POS_W-1:0] run_pos;
    logic             run_skip;
    logic             run_open;
    logic [POS_W-1:0] run_start;
    logic [LCP_W-1:0] run_prev;
    logic             run_growing;
    logic [POS_W-1:0] run_plateau;
    logic [POS_W-1:0] run_longest;
    logic [POS_W-1:0] run_count;

    cluster_report_t pending_clusters[$];

    int  error_count;
    int  items_sent;
    int  results_checked;
    int  clusters_checked;
    int  streams_sent;
    int  hold_count;
    int  cycle_count;
    bit  sender_idling;
    bit  receiver_idling;
    bit  hold_request;

    lcp_alpha_cluster_detector i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still expected",
                     cycle_count, pending_clusters.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic clear_stream();
        run_pos     = '0;
        run_skip    = 1'b1;
        run_open    = 1'b0;
        run_start   = '0;
        run_prev    = '1;
        run_growing = 1'b1;
        run_plateau = '0;
        run_longest = '0;
        run_count   = '0;
    endtask

    // Appends one expected result to the tail of the pending list.
    task automatic queue_report(input cluster_report_t rep);
        pending_clusters = {pending_clusters, rep};
    endtask

    task automatic record_cluster(input logic [POS_W-1:0] end_pos, input logic eos);
        cluster_report_t rep;
        rep.has_cluster = 1'b1;
        rep.start       = run_start;
        rep.length      = end_pos - run_start;
        if (rep.length > run_longest)
            run_longest = rep.length;
        if (run_count != POS_MAX)
            run_count = run_count + 1'b1;
        rep.longest       = run_longest;
        rep.count         = run_count;
        rep.end_of_stream = eos;
        queue_report(rep);
    endtask

    // Works out what one accepted transaction on the input side must produce.
    task automatic predict_lcp_item(input logic fn, input logic [LCP_W-1:0] v);
        cluster_report_t rep;
        logic [POS_W-1:0] q;
        q = run_pos;
        if (fn == FUNC_FLUSH)
        begin
            if (run_open)
                record_cluster(q, 1'b1);
            else
            begin
                rep.has_cluster   = 1'b0;
                rep.start         = '0;
                rep.length        = '0;
                rep.longest       = run_longest;
                rep.count         = run_count;
                rep.end_of_stream = 1'b1;
                queue_report(rep);
            end
            clear_stream();
            return;
        end
        if (run_skip)
        begin
            if (v < cfg_alpha)
                run_skip = 1'b0;
        end
        else if (v >= cfg_alpha)
        begin
            if (!run_open)
            begin
                run_open    = 1'b1;
                run_start   = q - 1'b1;
                run_growing = 1'b1;
                run_plateau = '0;
            end
            else if (cfg_positional)
            begin
                if (run_growing && v < run_prev)
                    run_growing = 1'b0;
                else if (!run_growing && v < run_prev)
                    run_plateau = '0;
                else if (!run_growing && v == run_prev)
                begin
                    if (run_plateau != POS_MAX)
                        run_plateau = run_plateau + 1'b1;
                end
                else if (!run_growing && v > run_prev)
                begin
                    // A rise after a fall: the valley floor starts a new cluster.
                    record_cluster(q - 1'b1 - run_plateau, 1'b0);
                    run_start   = q - run_plateau;
                    run_growing = 1'b1;
                    run_plateau = '0;
                end
            end
            if (cfg_positional)
                run_prev = v;
        end
        else
        begin
            if (run_open)
                record_cluster(q, 1'b0);
            run_open = 1'b0;
        end
        if (q != POS_MAX)
            run_pos = q + 1'b1;
    endtask

    // Entered at a falling edge; returns at the falling edge after the transaction
    // with tvalid still high, so the caller sends again or lowers it.
    task automatic send_item(input logic fn, input logic [LCP_W-1:0] v);
        if (sender_idling && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= v;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_lcp_item(fn, v);
        items_sent++;
        if (fn == FUNC_FLUSH)
            streams_sent++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_clusters.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Write then read back one register; only called while the block is idle.
    task automatic write_reg(input reg_idx_t idx, input logic [LCP_W-1:0] value);
        logic [APB_DATA_W-1:0] word;
        logic [APB_DATA_W-1:0] readback;
        word = $urandom();
        if (idx == REG_ALPHA)
        begin
            word[LCP_W-1:0] = value;
            readback = {{(APB_DATA_W-LCP_W){1'b0}}, value};
        end
        else
        begin
            word[0]  = value[0];
            readback = {{(APB_DATA_W-1){1'b0}}, value[0]};
        end
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        if (idx == REG_ALPHA)
            cfg_alpha = value;
        else
            cfg_positional = value[0];
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== readback)
        begin
            error_count++;
            if (error_count <= 10)
                $display("Register readback at %0h: expected %0h, got %0h",
                         paddr, readback, prdata);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    // Values wander around alpha so that runs, plateaus and valleys appear.
    task automatic send_random_stream(input int count, input bit with_flush);
        int walk;
        int r;
        logic [LCP_W-1:0] v;
        walk = $urandom_range(cfg_alpha, LCP_MAX);
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 6)
                v = $urandom_range(0, LCP_MAX);
            else if (r < 22 && cfg_alpha != 0)
                v = $urandom_range(0, cfg_alpha - 1);
            else
            begin
                walk += int'($urandom_range(0, 4)) - 2;
                if (walk < int'(cfg_alpha))
                    walk = cfg_alpha;
                if (walk > LCP_MAX)
                    walk = LCP_MAX;
                v = walk[LCP_W-1:0];
            end
            send_item(FUNC_SAMPLE, v);
        end
        if (with_flush)
            send_item(FUNC_FLUSH, $urandom_range(0, LCP_MAX));
    endtask

    task automatic pick_alpha();
        case ($urandom_range(0, 9))
            0: write_reg(REG_ALPHA, '0);
            1: write_reg(REG_ALPHA, LCP_MAX);
            2: write_reg(REG_ALPHA, $urandom_range(1, 4));
            3: write_reg(REG_ALPHA, $urandom_range(LCP_MAX - 4, LCP_MAX));
            default: write_reg(REG_ALPHA, $urandom_range(0, LCP_MAX));
        endcase
    endtask

    // With alpha at its reset value of zero no value ends the leading skip.
    task automatic test_leading_skip_only();
        send_item(FUNC_SAMPLE, 8'd255);
        send_item(FUNC_SAMPLE, 8'd0);
        send_item(FUNC_FLUSH, 8'd0);
        wait_idle();
    endtask

    task automatic test_basic_clusters();
        write_reg(REG_ALPHA, 8'd10);
        write_reg(REG_POS_MODE, 1'b0);
        send_item(FUNC_SAMPLE, 8'd20);
        send_item(FUNC_SAMPLE, 8'd5);
        send_item(FUNC_SAMPLE, 8'd12);
        send_item(FUNC_SAMPLE, 8'd13);
        send_item(FUNC_SAMPLE, 8'd3);
        send_item(FUNC_SAMPLE, 8'd10);
        send_item(FUNC_SAMPLE, 8'd255);
        send_item(FUNC_FLUSH, 8'd170);
        wait_idle();
    endtask

    task automatic test_alpha_extremes();
        write_reg(REG_ALPHA, LCP_MAX);
        send_item(FUNC_SAMPLE, 8'd0);
        send_item(FUNC_SAMPLE, 8'd255);
        send_item(FUNC_SAMPLE, 8'd255);
        send_item(FUNC_SAMPLE, 8'd254);
        send_item(FUNC_FLUSH, 8'd255);
        wait_idle();
    endtask

    // Rise, two falls, a plateau at the floor, then a rise that splits the cluster.
    task automatic test_positional_valleys();
        write_reg(REG_ALPHA, 8'd5);
        write_reg(REG_POS_MODE, 1'b1);
        send_item(FUNC_SAMPLE, 8'd0);
        send_item(FUNC_SAMPLE, 8'd10);
        send_item(FUNC_SAMPLE, 8'd12);
        send_item(FUNC_SAMPLE, 8'd8);
        send_item(FUNC_SAMPLE, 8'd7);
        send_item(FUNC_SAMPLE, 8'd7);
        send_item(FUNC_SAMPLE, 8'd9);
        send_item(FUNC_SAMPLE, 8'd2);
        send_item(FUNC_FLUSH, 8'd85);
        wait_idle();
    endtask

    task automatic test_random_streams(input int target);
        int start_items;
        start_items = items_sent;
        while (items_sent - start_items < target)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                wait_idle();
                pick_alpha();
                if ($urandom_range(0, 1) == 0)
                    write_reg(REG_POS_MODE, $urandom_range(0, 1));
            end
            sender_idling   = $urandom_range(0, 3) != 0;
            receiver_idling = $urandom_range(0, 3) != 0;
            send_random_stream($urandom_range(3, 40), $urandom_range(0, 9) != 0);
        end
        wait_idle();
    endtask

    // The receiver stalls for a long stretch while the sender keeps offering items.
    task automatic test_output_hold_off();
        write_reg(REG_ALPHA, 8'd40);
        write_reg(REG_POS_MODE, 1'b1);
        sender_idling = 1'b0;
        hold_request  = 1'b1;
        send_random_stream(30, 1'b1);
        wait_idle();
    endtask

    task automatic test_full_rate_tail();
        sender_idling   = 1'b0;
        receiver_idling = 1'b0;
        write_reg(REG_ALPHA, 8'd100);
        write_reg(REG_POS_MODE, 1'b1);
        send_random_stream(20, 1'b1);
        wait_idle();
        write_reg(REG_POS_MODE, 1'b0);
        send_random_stream(10, 1'b1);
        wait_idle();
    endtask

    // Result checker: every transaction on the output side is matched in order.
    always @(posedge clk)
    begin : check_results
        cluster_report_t seen;
        cluster_report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen.has_cluster   = m_tuser;
            seen.start         = m_tdata[POS_W-1:0];
            seen.length        = m_tdata[2*POS_W-1:POS_W];
            seen.longest       = m_tdata[3*POS_W-1:2*POS_W];
            seen.count         = m_tdata[4*POS_W-1:3*POS_W];
            seen.end_of_stream = m_tlast;
            results_checked++;
            if (seen.has_cluster)
                clusters_checked++;
            if (pending_clusters.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("Unexpected result: has=%0b start=%0d len=%0d eos=%0b",
                             seen.has_cluster, seen.start, seen.length,
                             seen.end_of_stream);
            end
            else
            begin
                want = pending_clusters.pop_front();
                if (seen.has_cluster !== want.has_cluster || seen.start !== want.start
                    || seen.length !== want.length || seen.longest !== want.longest
                    || seen.count !== want.count
                    || seen.end_of_stream !== want.end_of_stream)
                begin
                    error_count++;
                    if (error_count <= 10)
                    begin
                        $display("Mismatch on result %0d:", results_checked);
                        $display("  expected has=%0b start=%0d len=%0d longest=%0d",
                                 want.has_cluster, want.start, want.length, want.longest);
                        $display("           count=%0d eos=%0b",
                                 want.count, want.end_of_stream);
                        $display("  actual   has=%0b start=%0d len=%0d longest=%0d",
                                 seen.has_cluster, seen.start, seen.length, seen.longest);
                        $display("           count=%0d eos=%0b",
                                 seen.count, seen.end_of_stream);
                    end
                end
            end
        end
    end

    // Output side ready: random stalls, and one long hold-off when requested.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                m_tready <= 1'b1;
                hold_request = 1'b0;
                hold_count++;
            end
            else if (receiver_idling && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        clk      = 1'b0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = FUNC_SAMPLE;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        error_count      = 0;
        items_sent       = 0;
        results_checked  = 0;
        clusters_checked = 0;
        streams_sent     = 0;
        hold_count       = 0;
        cycle_count      = 0;
        sender_idling    = 1'b1;
        receiver_idling  = 1'b1;
        hold_request     = 1'b0;
        cfg_alpha        = '0;
        cfg_positional   = 1'b0;
        clear_stream();
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_leading_skip_only();
        test_basic_clusters();
        test_alpha_extremes();
        test_positional_valleys();
        test_random_streams(380);
        test_output_hold_off();
        test_full_rate_tail();

        $display("Sent %0d items in %0d flushed streams; checked %0d results, %0d clusters.",
                 items_sent, streams_sent, results_checked, clusters_checked);
        $display("Covered both modes, alpha extremes, valleys and %0d long output stalls.",
                 hold_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/lcpac_pkg.sv
sv/lcpac_core.sv
sv/lcp_alpha_cluster_detector.sv
sv/lcpac_checker.sv
tb/tb.sv
